[rtl/brg_pkg.sv]
// ----------------------------------------------------------------------------
// brg_pkg
// Shared types and constants of the bounded random generator.
// ----------------------------------------------------------------------------
package brg_pkg;

    localparam logic [63:0] LCG_MULT      = 64'd6364136223846793005;
    localparam logic [63:0] RESET_SEED    = 64'd1234567890;
    localparam logic [63:0] RESET_INCR    = 64'd6364136223846793005;
    localparam int          REDRAW_LIMIT  = 256;
    localparam int          TRY_W         = $clog2(REDRAW_LIMIT) + 1;

    // request kinds as they arrive on the input channel
    localparam logic [1:0] KIND_RAW   = 2'd0;
    localparam logic [1:0] KIND_UPPER = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;

    // register indexes (byte address bit 3)
    localparam logic REG_SEED = 1'b0;
    localparam logic REG_INCR = 1'b1;

    typedef enum logic [1:0] {
        CLS_RAW,
        CLS_RANGE,
        CLS_EMPTY
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [31:0] lower;
        logic [31:0] span;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THR,
        ST_MUL,
        ST_CHK,
        ST_RED,
        ST_OUT
    } t_back_state;

    typedef struct packed {
        logic start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

endpackage

[rtl/bounded_random_generator_top.sv]
// ----------------------------------------------------------------------------
// bounded_random_generator_top
// 64-bit LCG with xor-shift output; raw draws and unbiased ranged draws.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_valid/o_stall with i_kind, i_lower_bound and
//   i_upper_bound; results leave on o_valid/i_stall with o_random_value and
//   o_empty_range. A transfer happens when valid is high and stall is low.
//   A front end sorts requests into a two-entry queue; the back end runs one
//   job at a time.
//   A ranged draw computes the threshold remainder, then draws (the LCG
//   step shares one 32x32 multiplier over four phases) and redraws while
//   the draw lies below the threshold, at most 256 draws, then takes the
//   final remainder. An empty range skips the generator.
//   The serial remainder unit sets the ranged rate.
//   Reset loads seed 1234567890 and the default increment, empties the
//   queue and the result register. While the receiver stalls, the result
//   holds, one more job finishes in the back end and then the queue fills.
//   APB: seed at 0x0, increment at 0x8; writing the seed reloads the state.
// ----------------------------------------------------------------------------
module bounded_random_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_lower_bound,
    input  logic [31:0] i_upper_bound,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_random_value,
    output logic        o_empty_range,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import brg_pkg::*;

    logic [63:0] r_seed;
    logic [63:0] r_incr;
    logic        w_wr;
    logic        w_seed_we;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    t_job        w_job_in;
    t_job        w_job_out;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    assign w_seed_we = w_wr && (paddr[3] == REG_SEED);
    assign prdata    = (paddr[3] == REG_INCR) ? r_incr : r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= RESET_SEED;
            r_incr <= RESET_INCR;
        end else if (w_wr) begin
            if (paddr[3] == REG_SEED) begin
                r_seed <= pwdata;
            end else begin
                r_incr <= pwdata;
            end
        end
    end

    brg_front u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_job         (w_job_in)
    );

    brg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    brg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (w_seed_we),
        .i_seed         (pwdata),
        .i_incr         (r_incr),
        .i_q_empty      (w_empty),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_random_value (o_random_value),
        .o_empty_range  (o_empty_range)
    );

endmodule

[rtl/brg_front.sv]
// ----------------------------------------------------------------------------
// brg_front
// Accepts requests, works out the span and classifies them for the back end.
// ----------------------------------------------------------------------------
module brg_front (
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_kind,
    input  logic [31:0]       i_lower_bound,
    input  logic [31:0]       i_upper_bound,
    input  logic              i_full,
    output logic              o_push,
    output brg_pkg::t_job     o_job
);
    import brg_pkg::*;

    logic [31:0] w_lower;
    logic [31:0] w_span;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_lower = (i_kind == KIND_RANGE) ? i_lower_bound : 32'd0;
        w_span  = i_upper_bound - w_lower;
        o_job.lower = w_lower;
        o_job.span  = w_span;
        if (i_kind != KIND_UPPER && i_kind != KIND_RANGE) begin
            o_job.cls = CLS_RAW;
        end else if (w_span == 32'd0) begin
            o_job.cls = CLS_EMPTY;
        end else begin
            o_job.cls = CLS_RANGE;
        end
    end

endmodule

[rtl/brg_fifo.sv]
// ----------------------------------------------------------------------------
// brg_fifo
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
module brg_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  brg_pkg::t_job     i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output brg_pkg::t_job     o_job
);
    import brg_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[rtl/brg_div.sv]
// ----------------------------------------------------------------------------
// brg_div
// Restoring radix-2 remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brg_pkg::t_div_req i_req,
    output logic              o_busy,
    output logic [31:0]       o_rem
);
    import brg_pkg::*;

    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_dsr;
    logic [5:0]  r_cnt;
    logic [32:0] w_try;

    assign o_busy = (r_cnt != 6'd0);
    assign o_rem  = r_rem;
    assign w_try  = {r_rem, r_dvd[31]};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= 32'd0;
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (o_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            // partial remainder stays below the divisor, so 32 bits hold it
            if (w_try >= {1'b0, r_dsr}) begin
                r_rem <= w_try[31:0] - r_dsr;
            end else begin
                r_rem <= w_try[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_req.start) begin
            r_cnt <= 6'd32;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

endmodule

[rtl/brg_back.sv]
// ----------------------------------------------------------------------------
// brg_back
// Generator state, four-phase LCG step, rejection loop and result register.
// ----------------------------------------------------------------------------
module brg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_seed_we,
    input  logic [63:0]       i_seed,
    input  logic [63:0]       i_incr,
    input  logic              i_q_empty,
    input  brg_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_random_value,
    output logic              o_empty_range
);
    import brg_pkg::*;

    t_back_state       r_st, n_st;
    t_job              r_job;
    logic [63:0]       r_gen, n_gen;
    logic [63:0]       r_p0;
    logic [31:0]       r_p1, r_p2;
    logic [1:0]        r_ph;
    logic [31:0]       r_thr, n_thr;
    logic [TRY_W-1:0]  r_tries;
    logic [31:0]       r_res, n_res;
    logic              r_res_empty, n_res_empty;
    logic              r_out_valid;
    logic [31:0]       r_out_val;
    logic              r_out_empty;
    logic [31:0]       w_ma, w_mb;
    logic [63:0]       w_prod;
    logic [31:0]       w_draw;
    logic              w_out_free;
    logic              w_load_out;
    logic              w_commit;
    t_div_req          w_div;
    logic              w_div_busy;
    logic [31:0]       w_div_rem;

    brg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div),
        .o_busy  (w_div_busy),
        .o_rem   (w_div_rem)
    );

    assign w_draw     = r_gen[31:0] ^ {1'b0, r_gen[63:33]};
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_commit   = (r_st == ST_MUL) && (r_ph == 2'd3);

    // one shared 32x32 multiplier, operands picked by phase
    always_comb begin
        unique case (r_ph)
            2'd0:    begin w_ma = r_gen[31:0];  w_mb = LCG_MULT[31:0];  end
            2'd1:    begin w_ma = r_gen[63:32]; w_mb = LCG_MULT[31:0];  end
            default: begin w_ma = r_gen[31:0];  w_mb = LCG_MULT[63:32]; end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_job.cls)
                        CLS_EMPTY: n_st = ST_OUT;
                        CLS_RANGE: n_st = ST_THR;
                        default:   n_st = ST_MUL;
                    endcase
                end
            end
            ST_THR:  if (!w_div_busy) n_st = ST_MUL;
            ST_MUL:  if (r_ph == 2'd3) n_st = ST_CHK;
            ST_CHK: begin
                if (r_job.cls != CLS_RANGE) begin
                    n_st = ST_OUT;
                end else if (w_draw < r_thr && !r_tries[TRY_W-1]) begin
                    n_st = ST_MUL;
                end else begin
                    n_st = ST_RED;
                end
            end
            ST_RED:  if (!w_div_busy) n_st = ST_OUT;
            ST_OUT:  if (w_out_free) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        o_pop        = 1'b0;
        w_div.start  = 1'b0;
        w_div.dividend = w_draw;
        w_div.divisor  = r_job.span;
        n_thr        = r_thr;
        n_res        = r_res;
        n_res_empty  = r_res_empty;
        w_load_out   = 1'b0;
        n_gen        = {r_p0[63:32] + r_p1 + r_p2, r_p0[31:0]} + i_incr;
        unique case (r_st)
            ST_IDLE: begin
                o_pop          = !i_q_empty;
                w_div.start    = !i_q_empty && (i_job.cls == CLS_RANGE);
                w_div.dividend = 32'd0 - i_job.span;
                w_div.divisor  = i_job.span;
                n_res          = 32'd0;
                n_res_empty    = 1'b1;
            end
            ST_THR: n_thr = w_div_rem;
            ST_CHK: begin
                n_res       = w_draw;
                n_res_empty = 1'b0;
                w_div.start = (r_job.cls == CLS_RANGE) &&
                              !(w_draw < r_thr && !r_tries[TRY_W-1]);
            end
            ST_RED: n_res = r_job.lower + w_div_rem;
            ST_OUT: w_load_out = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        r_thr       <= n_thr;
        r_res       <= n_res;
        r_res_empty <= n_res_empty;
        unique case (r_ph)
            2'd0:    r_p0 <= w_prod;
            2'd1:    r_p1 <= w_prod[31:0];
            2'd2:    r_p2 <= w_prod[31:0];
            default: ;
        endcase
        if (w_load_out) begin
            r_out_val   <= r_res;
            r_out_empty <= r_res_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_gen       <= RESET_SEED;
            r_ph        <= 2'd0;
            r_tries     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_seed_we) begin
                r_gen <= i_seed;
            end else if (w_commit) begin
                r_gen <= n_gen;
            end
            r_ph <= (r_st == ST_MUL) ? r_ph + 2'd1 : 2'd0;
            if (o_pop) begin
                r_tries <= '0;
            end else if (w_commit) begin
                r_tries <= r_tries + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_random_value = r_out_val;
    assign o_empty_range  = r_out_empty;

endmodule

[rtl/brg_checker.sv]
// ----------------------------------------------------------------------------
// brg_checker
// Port-level checks of the bounded random generator, bound to the top level.
// ----------------------------------------------------------------------------
module brg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_random_value,
    input logic        o_empty_range
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_random_value) &&
        $stable(o_empty_range))
        else $error("stalled result changed");

    // empty range answers zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_range |-> o_random_value == 32'd0)
        else $error("empty range with nonzero value");

    // reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind bounded_random_generator_top brg_checker u_brg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_random_value (o_random_value),
    .o_empty_range  (o_empty_range)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the bounded random generator: raw draws, ranged draws with bias
// rejection, empty and wrapped ranges, seed and increment register writes,
// under several idle and stall patterns against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import brg_pkg::*;

    localparam logic [3:0] ADDR_SEED = 4'h0;
    localparam logic [3:0] ADDR_INCR = 4'h8;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_lower_bound = '0;
    logic [31:0] i_upper_bound = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_random_value;
    logic        o_empty_range;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    bounded_random_generator_top dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] value;
        logic        empty;
    } t_draw;

    logic [63:0] lcg_state;
    logic [63:0] lcg_incr;
    t_draw       pending_draws[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          failed = 1'b0;

    function automatic logic [31:0] next_word();
        lcg_state = lcg_state * LCG_MULT + lcg_incr;
        return 32'(lcg_state ^ (lcg_state >> 33));
    endfunction

    function automatic t_draw predict_draw(logic [1:0] kind, logic [31:0] lo,
                                           logic [31:0] hi);
        t_draw       res;
        logic [31:0] span;
        logic [31:0] thr;
        logic [31:0] w;
        int          tries;
        res = '0;
        if (kind == KIND_RAW || kind == KIND_SPARE) begin
            res.value = next_word();
            return res;
        end
        if (kind == KIND_UPPER) lo = '0;
        span = hi - lo;
        if (span == 0) begin
            res.empty = 1'b1;
            return res;
        end
        thr = 32'((64'h1_0000_0000 - 64'(span)) % 64'(span));
        w = next_word();
        tries = 1;
        while (w < thr && tries < REDRAW_LIMIT) begin
            w = next_word();
            tries++;
        end
        res.value = lo + w % span;
        return res;
    endfunction

    // receiver: random stall, check every transfer
    always @(posedge i_clk) begin
        t_draw want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_draws.size() == 0) begin
                $error("unexpected result value=%h empty=%b", o_random_value,
                       o_empty_range);
                failed = 1'b1;
            end else begin
                want = pending_draws.pop_front();
                if (o_random_value !== want.value) begin
                    $error("random_value expected %h actual %h", want.value,
                           o_random_value);
                    failed = 1'b1;
                end
                if (o_empty_range !== want.empty) begin
                    $error("empty_range expected %b actual %b", want.empty,
                           o_empty_range);
                    failed = 1'b1;
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_request(logic [1:0] kind, logic [31:0] lo, logic [31:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_lower_bound <= lo;
        i_upper_bound <= hi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_draws.push_back(predict_draw(kind, lo, hi));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] addr, logic [63:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SEED) lcg_state = data;
        else lcg_incr = data;
    endtask

    function automatic logic [31:0] rand_bound();
        case ($urandom_range(5))
            0: return $urandom_range(16);
            1: return 32'hFFFF_FFFF - $urandom_range(16);
            2: return 32'h8000_0000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_request(KIND_RAW, '0, '0);
        send_request(KIND_RAW, '1, '1);
        send_request(KIND_SPARE, 32'h1234, 32'h5);
        send_request(KIND_UPPER, '0, '0);
        send_request(KIND_UPPER, '1, 32'd1);
        send_request(KIND_UPPER, '0, 32'd3);
        send_request(KIND_UPPER, '0, '1);
        send_request(KIND_UPPER, '0, 32'h8000_0001);
        send_request(KIND_RANGE, 32'd7, 32'd7);
        send_request(KIND_RANGE, '1, '1);
        send_request(KIND_RANGE, 32'd10, 32'd20);
        send_request(KIND_RANGE, '1, 32'd5);
        send_request(KIND_RANGE, 32'hFFFF_FFF0, 32'h10);
        send_request(KIND_RANGE, '0, '1);
        send_request(KIND_RANGE, 32'd1, '0);
        send_request(KIND_RANGE, 32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count) send_request(2'($urandom_range(3)), rand_bound(), rand_bound());
        wait_drained();
    endtask

    // even increment: rejection may run into the redraw cap
    task automatic test_degenerate_increment();
        write_reg(ADDR_INCR, 64'd0);
        write_reg(ADDR_SEED, 64'd0);
        repeat (4) send_request(KIND_UPPER, '0, 32'h8000_0001);
        wait_drained();
        write_reg(ADDR_INCR, 64'd2);
        write_reg(ADDR_SEED, 64'd4);
        repeat (4) send_request(KIND_RANGE, 32'd3, 32'hC000_0000);
        wait_drained();
    endtask

    initial begin
        lcg_state = RESET_SEED;
        lcg_incr = RESET_INCR;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_reg(ADDR_SEED, '1);
        write_reg(ADDR_INCR, '1);
        test_random(300);
        send_idle_pct = 50;
        write_reg(ADDR_SEED, '0);
        write_reg(ADDR_INCR, 64'd1);
        test_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 50;
        write_reg(ADDR_SEED, {$urandom, $urandom});
        write_reg(ADDR_INCR, {$urandom, $urandom} | 64'd1);
        test_random(300);
        send_idle_pct = 29;
        recv_stall_pct = 29;
        test_degenerate_increment();
        write_reg(ADDR_INCR, RESET_INCR);
        write_reg(ADDR_SEED, 64'hAAAA_5555_0F0F_F0F0);
        test_random(300);
        if (!failed) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
